// ----- rtl/multi_channel_pwm_meter_defines.svh -----
// Assertion macros for the PWM meter.
`ifndef MULTI_CHANNEL_PWM_METER_DEFINES_SVH
`define MULTI_CHANNEL_PWM_METER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MCPM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("mcpm assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define MCPM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("mcpm assertion failed");

`endif

// ----- rtl/mcpm_pkg.sv -----
package mcpm_pkg;

	localparam int CHANNELS   = 8;
	localparam int IN_WIDTH   = 8;
	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W      = 16;
	localparam int TPR_W      = 16;
	localparam int TPM_W      = 10;
	localparam int PLEN_W     = TPR_W + 1;
	localparam int DUTY_W     = 7;
	localparam int FREQ_W     = 10;
	localparam int TOTAL_W    = 32;
	localparam int CHAN_OUT_W = 3;
	// 1000 * 65535 and 65536 * 1000 both fit in 26 bits
	localparam int DIV_W      = 26;
	localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_REPORT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD_MS   = 2'd1;

	localparam int DUTY_SCALE = 100;
	localparam int FREQ_SCALE = 1000;
	localparam int DUTY_MAX   = 100;
	localparam int FREQ_MAX   = 1000;

	typedef struct packed {
		logic [CNT_W-1:0] high;
		logic [CNT_W-1:0] low;
		logic [CNT_W-1:0] rise;
	} cnt_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
	} div_rsp_t;

endpackage

// ----- rtl/mcpm_if.sv -----
interface mcpm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] pin_levels;

	modport source (output valid, output pin_levels, input ready);
	modport sink (input valid, input pin_levels, output ready);
endinterface

interface mcpm_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] tick_total;
	logic [2:0]  channel;
	logic [15:0] high_samples;
	logic [15:0] low_samples;
	logic [15:0] rising_edges;
	logic [6:0]  duty_percent;
	logic [9:0]  frequency_hz;
	logic        last_channel;

	modport source (output valid, output tick_total, output channel, output high_samples,
		output low_samples, output rising_edges, output duty_percent,
		output frequency_hz, output last_channel, input ready);
	modport sink (input valid, input tick_total, input channel, input high_samples,
		input low_samples, input rising_edges, input duty_percent,
		input frequency_hz, input last_channel, output ready);
endinterface

interface mcpm_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/mcpm_cnt_ram.sv -----
module mcpm_cnt_ram (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [mcpm_pkg::CH_W-1:0] rd_addr,
	output mcpm_pkg::cnt_t           rd_data,
	input  logic                     wr_en,
	input  logic [mcpm_pkg::CH_W-1:0] wr_addr,
	input  mcpm_pkg::cnt_t           wr_data
);
	import mcpm_pkg::*;

	cnt_t                mem [CHANNELS];
	logic [CHANNELS-1:0] vld_q;
	cnt_t                rd_data_q;
	logic                rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- rtl/mcpm_div.sv -----
module mcpm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mcpm_pkg::div_req_t req,
	output mcpm_pkg::div_rsp_t rsp
);
	import mcpm_pkg::*;

	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_W:0]       shifted;
	logic [DIV_W:0]       diff;

	// restoring division, one quotient bit per cycle
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!diff[DIV_W]) begin
				rem_q <= diff[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ----- rtl/multi_channel_pwm_meter.sv -----
// Multi-channel PWM meter.
// samples: one transfer per sample tick, pin_levels bit i is the level of channel i.
// reports: at the end of each measurement period, one transfer per channel in
//   channel order; last_channel marks the final one.
// cfg: register writes, index 0 ticks_per_report, 1 tick_period_ms; always ready.
//   Write only while the block is idle.
// Per-channel high/low/rise counts live in an 8-entry counter memory that is
// swept read-modify-write, one channel per cycle; samples.ready stays low
// during the sweep, so no new tick is taken until it is done.
// At a period end each channel is read, cleared, and its duty and frequency
// are found with one bit-serial 26-bit divider used twice, duty then
// frequency; the channel reports follow the counter sweep.
// Reset: counters, tick total and previous levels clear; registers go to
// 100 and 1. The counter memory needs no clearing pass.
// A stalled receiver holds the current report in the output register; the
// next channel is finished and then waits for that register to free up.
`include "multi_channel_pwm_meter_defines.svh"

module multi_channel_pwm_meter (
	input logic        clk,
	input logic        arst_n,
	mcpm_in_if.sink    samples,
	mcpm_out_if.source reports,
	mcpm_cfg_if.sink   cfg
);
	import mcpm_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_UPD    = 7'b0000010,
		ST_RPT_RD = 7'b0000100,
		ST_RPT_LD = 7'b0001000,
		ST_DUTY   = 7'b0010000,
		ST_FREQ   = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

	localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	state_t              state_q;
	logic [TPR_W-1:0]    tpr_q;
	logic [TPM_W-1:0]    tpm_q;
	logic [PLEN_W-1:0]   plen;
	logic [TPM_W-1:0]    ms;
	logic [CHANNELS-1:0] lvl_d;
	logic [CHANNELS-1:0] lvl_q;
	logic [CHANNELS-1:0] prev_q;
	logic [TOTAL_W-1:0]  tick_q;
	logic [TPR_W-1:0]    pos_q;
	logic [PLEN_W-1:0]   pos_nxt;
	logic                report_q;
	logic [DIV_W-1:0]    den_q;
	logic [CH_W-1:0]     rd_ch_q;
	logic                rd_done_q;
	logic                vld_s1;
	logic [CH_W-1:0]     ch_s1;
	logic [CH_W-1:0]     ch_q;
	cnt_t                cnt_q;
	logic [DUTY_W-1:0]   duty_q;
	logic [FREQ_W-1:0]   freq_q;
	logic                out_vld_q;
	logic                out_free;
	logic                accept;

	logic                rd_en;
	logic [CH_W-1:0]     rd_addr;
	cnt_t                rd_data;
	logic                wr_en;
	logic [CH_W-1:0]     wr_addr;
	cnt_t                wr_data;
	cnt_t                upd;
	logic                lvl_cur;
	logic                lvl_prev;

	div_req_t            div_req;
	div_rsp_t            div_rsp;

	// channels beyond the input width read low
	for (genvar i = 0; i < CHANNELS; i++) begin : g_lvl
		if (i < IN_WIDTH) begin : g_pin
			assign lvl_d[i] = samples.pin_levels[i];
		end else begin : g_zero
			assign lvl_d[i] = 1'b0;
		end
	end

	// zero period length acts as 65536, zero tick period as 1
	assign plen    = {(tpr_q == '0), tpr_q};
	assign ms      = (tpm_q == '0) ? TPM_W'(1) : tpm_q;
	assign pos_nxt = {1'b0, pos_q} + 1'b1;

	assign accept        = samples.valid && samples.ready;
	assign samples.ready = (state_q == ST_IDLE);
	assign cfg.ready     = 1'b1;
	assign out_free      = !out_vld_q || reports.ready;

	// counter memory access
	assign rd_en   = ((state_q == ST_UPD) && !rd_done_q) || (state_q == ST_RPT_RD);
	assign rd_addr = (state_q == ST_UPD) ? rd_ch_q : ch_q;
	assign wr_en   = ((state_q == ST_UPD) && vld_s1) || (state_q == ST_RPT_LD);
	assign wr_addr = (state_q == ST_UPD) ? ch_s1 : ch_q;
	assign wr_data = (state_q == ST_UPD) ? upd : '0;

	assign lvl_cur  = lvl_q[ch_s1];
	assign lvl_prev = prev_q[ch_s1];

	always_comb begin
		upd = rd_data;
		if (lvl_cur) begin
			upd.high = sat_inc(rd_data.high);
		end else begin
			upd.low = sat_inc(rd_data.low);
		end
		if (lvl_cur && !lvl_prev) begin
			upd.rise = sat_inc(rd_data.rise);
		end
	end

	// divider: duty first, straight from the memory read, then frequency
	always_comb begin
		div_req.start = (state_q == ST_RPT_LD) || ((state_q == ST_DUTY) && div_rsp.done);
		if (state_q == ST_RPT_LD) begin
			div_req.num = DIV_W'(rd_data.high) * DIV_W'(DUTY_SCALE);
			div_req.den = DIV_W'(plen);
		end else begin
			div_req.num = DIV_W'(cnt_q.rise) * DIV_W'(FREQ_SCALE);
			div_req.den = den_q;
		end
	end

	mcpm_cnt_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	mcpm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpr_q <= TPR_W'(100);
			tpm_q <= TPM_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_TICKS_PER_REPORT: tpr_q <= cfg.data[TPR_W-1:0];
				REG_TICK_PERIOD_MS:   tpm_q <= cfg.data[TPM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			prev_q    <= '0;
			tick_q    <= '0;
			pos_q     <= '0;
			report_q  <= 1'b0;
			rd_ch_q   <= '0;
			rd_done_q <= 1'b0;
			vld_s1    <= 1'b0;
			ch_s1     <= '0;
			ch_q      <= '0;
			out_vld_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_UPD) && !rd_done_q;
			ch_s1  <= rd_ch_q;
			if ((state_q == ST_EMIT) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (reports.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						tick_q    <= tick_q + 1'b1;
						rd_ch_q   <= '0;
						rd_done_q <= 1'b0;
						if (pos_nxt < plen) begin
							pos_q    <= pos_nxt[TPR_W-1:0];
							report_q <= 1'b0;
						end else begin
							pos_q    <= '0;
							report_q <= 1'b1;
						end
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (rd_en) begin
						if (rd_ch_q == LAST_CH) begin
							rd_done_q <= 1'b1;
						end else begin
							rd_ch_q <= rd_ch_q + 1'b1;
						end
					end
					if (vld_s1 && (ch_s1 == LAST_CH)) begin
						prev_q <= lvl_q;
						ch_q   <= '0;
						state_q <= report_q ? ST_RPT_RD : ST_IDLE;
					end
				end
				ST_RPT_RD: state_q <= ST_RPT_LD;
				ST_RPT_LD: state_q <= ST_DUTY;
				ST_DUTY: begin
					if (div_rsp.done) begin
						state_q <= ST_FREQ;
					end
				end
				ST_FREQ: begin
					if (div_rsp.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (ch_q == LAST_CH) begin
							state_q <= ST_IDLE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= ST_RPT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lvl_q <= lvl_d;
			den_q <= DIV_W'(plen * ms);
		end
		if (state_q == ST_RPT_LD) begin
			cnt_q <= rd_data;
		end
		if ((state_q == ST_DUTY) && div_rsp.done) begin
			duty_q <= (div_rsp.quo > DIV_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX)
			                                          : div_rsp.quo[DUTY_W-1:0];
		end
		if ((state_q == ST_FREQ) && div_rsp.done) begin
			freq_q <= (div_rsp.quo > DIV_W'(FREQ_MAX)) ? FREQ_W'(FREQ_MAX)
			                                          : div_rsp.quo[FREQ_W-1:0];
		end
		if ((state_q == ST_EMIT) && out_free) begin
			reports.tick_total   <= tick_q;
			reports.channel      <= CHAN_OUT_W'(ch_q);
			reports.high_samples <= cnt_q.high;
			reports.low_samples  <= cnt_q.low;
			reports.rising_edges <= cnt_q.rise;
			reports.duty_percent <= duty_q;
			reports.frequency_hz <= freq_q;
			reports.last_channel <= (ch_q == LAST_CH);
		end
	end

	assign reports.valid = out_vld_q;

	`MCPM_ASSERT_NOW(a_no_same_entry, rd_en && wr_en, rd_addr != wr_addr)
	`MCPM_ASSERT_NOW(a_div_done_state, div_rsp.done, (state_q == ST_DUTY) || (state_q == ST_FREQ))
	`MCPM_ASSERT_NOW(a_ratio_range, reports.valid,
		(reports.duty_percent <= 7'd100) && (reports.frequency_hz <= 10'd1000))
	`MCPM_ASSERT_NEXT(a_quiet_tick, (state_q == ST_UPD) && vld_s1 && (ch_s1 == LAST_CH) && !report_q,
		state_q == ST_IDLE)

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
module tb;
	import mcpm_pkg::*;

	// indexes with no register behind them; writes must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam int SETTLE_CYCLES  = 40;
	localparam int DRAIN_LIMIT    = 200000;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int HOLD_CYCLES    = 3000;
	localparam int RANDOM_TICKS   = 200;
	localparam int ZERO_LEN_TICKS = 8;

	typedef struct packed {
		logic [TOTAL_W-1:0]    tick_total;
		logic [CHAN_OUT_W-1:0] channel;
		logic [CNT_W-1:0]      high_samples;
		logic [CNT_W-1:0]      low_samples;
		logic [CNT_W-1:0]      rising_edges;
		logic [DUTY_W-1:0]     duty_percent;
		logic [FREQ_W-1:0]     frequency_hz;
		logic                  last_channel;
	} meter_rec_t;

	class pwm_meter_scoreboard;
		logic [CNT_W-1:0]   high_cnt[CHANNELS];
		logic [CNT_W-1:0]   low_cnt[CHANNELS];
		logic [CNT_W-1:0]   rise_cnt[CHANNELS];
		logic [IN_WIDTH-1:0] prev_levels;
		logic [TOTAL_W-1:0] tick_count;
		logic [TPR_W-1:0]   period_pos;
		logic [TPR_W-1:0]   ticks_per_report;
		logic [TPM_W-1:0]   tick_period_ms;
		meter_rec_t         expected_reports[$];
		int                 ticks_seen;
		int                 reports_checked;
		int                 regs_written;
		int                 mismatches;

		function new();
			for (int ch = 0; ch < CHANNELS; ch++) begin
				high_cnt[ch] = '0;
				low_cnt[ch] = '0;
				rise_cnt[ch] = '0;
			end
			prev_levels = '0;
			tick_count = '0;
			period_pos = '0;
			ticks_per_report = 16'd100;
			tick_period_ms = 10'd1;
			ticks_seen = 0;
			reports_checked = 0;
			regs_written = 0;
			mismatches = 0;
		endfunction

		function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
			return (v == '1) ? v : v + 1'b1;
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			regs_written++;
			if (idx == REG_TICKS_PER_REPORT)
				ticks_per_report = data[TPR_W-1:0];
			else if (idx == REG_TICK_PERIOD_MS)
				tick_period_ms = data[TPM_W-1:0];
		endfunction

		// one sample tick; at a period end queue one report per channel
		function void note_tick(logic [IN_WIDTH-1:0] levels);
			meter_rec_t r;
			longint     plen;
			longint     ms;
			longint     next_pos;
			longint     duty;
			longint     freq;
			ticks_seen++;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				if (levels[ch])
					high_cnt[ch] = bump(high_cnt[ch]);
				else
					low_cnt[ch] = bump(low_cnt[ch]);
				if (levels[ch] && !prev_levels[ch])
					rise_cnt[ch] = bump(rise_cnt[ch]);
			end
			prev_levels = levels;
			tick_count = tick_count + 1'b1;
			plen = (ticks_per_report == 0) ? 65536 : ticks_per_report;
			ms = (tick_period_ms == 0) ? 1 : tick_period_ms;
			next_pos = longint'(period_pos) + 1;
			if (next_pos < plen) begin
				period_pos = next_pos[TPR_W-1:0];
				return;
			end
			period_pos = '0;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				duty = (DUTY_SCALE * longint'(high_cnt[ch])) / plen;
				freq = (FREQ_SCALE * longint'(rise_cnt[ch])) / (plen * ms);
				if (duty > DUTY_MAX)
					duty = DUTY_MAX;
				if (freq > FREQ_MAX)
					freq = FREQ_MAX;
				r.tick_total = tick_count;
				r.channel = ch[CHAN_OUT_W-1:0];
				r.high_samples = high_cnt[ch];
				r.low_samples = low_cnt[ch];
				r.rising_edges = rise_cnt[ch];
				r.duty_percent = duty[DUTY_W-1:0];
				r.frequency_hz = freq[FREQ_W-1:0];
				r.last_channel = (ch == CHANNELS - 1);
				expected_reports.push_back(r);
				high_cnt[ch] = '0;
				low_cnt[ch] = '0;
				rise_cnt[ch] = '0;
			end
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		endtask

		task compare(string field, logic [31:0] got, logic [31:0] want, meter_rec_t ctx);
			if (got !== want)
				report_mismatch($sformatf("ch %0d at tick %0d, %s: got %0d, expected %0d",
					ctx.channel, ctx.tick_total, field, got, want));
		endtask

		task check_report(meter_rec_t got);
			meter_rec_t want;
			reports_checked++;
			if (expected_reports.size() == 0) begin
				report_mismatch($sformatf("report for ch %0d at tick %0d with none expected",
					got.channel, got.tick_total));
				return;
			end
			want = expected_reports.pop_front();
			compare("tick_total", got.tick_total, want.tick_total, want);
			compare("channel", got.channel, want.channel, want);
			compare("high_samples", got.high_samples, want.high_samples, want);
			compare("low_samples", got.low_samples, want.low_samples, want);
			compare("rising_edges", got.rising_edges, want.rising_edges, want);
			compare("duty_percent", got.duty_percent, want.duty_percent, want);
			compare("frequency_hz", got.frequency_hz, want.frequency_hz, want);
			compare("last_channel", got.last_channel, want.last_channel, want);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic hold_request;
	int   cycle_count;
	int   pwm_step;
	logic [IN_WIDTH-1:0] last_levels;
	pwm_meter_scoreboard sb;

	mcpm_in_if  samples();
	mcpm_out_if reports();
	mcpm_cfg_if cfg();

	multi_channel_pwm_meter uut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.reports(reports),
		.cfg(cfg)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		meter_rec_t got;
		if (arst_n && cfg.valid && cfg.ready)
			sb.write_reg(cfg.index, cfg.data);
		if (arst_n && samples.valid && samples.ready)
			sb.note_tick(samples.pin_levels);
		if (arst_n && reports.valid && reports.ready) begin
			got.tick_total = reports.tick_total;
			got.channel = reports.channel;
			got.high_samples = reports.high_samples;
			got.low_samples = reports.low_samples;
			got.rising_edges = reports.rising_edges;
			got.duty_percent = reports.duty_percent;
			got.frequency_hz = reports.frequency_hz;
			got.last_channel = reports.last_channel;
			sb.check_report(got);
		end
	end

	// receiver: stall rate is redrawn whenever stretch runs out; one long hold-off on request
	initial begin
		int stall_pct;
		int stretch;
		bit held;
		reports.ready = 1'b0;
		stall_pct = 0;
		stretch = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !held) begin
				reports.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				held = 1'b1;
			end
			if (stretch == 0) begin
				case ($urandom_range(0, 4))
					0, 1: stall_pct = 0;
					2: stall_pct = 20;
					3: stall_pct = 50;
					default: stall_pct = 85;
				endcase
				stretch = 150;
			end
			stretch--;
			reports.ready = ($urandom_range(0, 99) >= stall_pct);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d reports outstanding", cycle_count, sb.pending());
		$display("Simulation FAILED");
		$finish;
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_tick(input logic [IN_WIDTH-1:0] levels);
		samples.valid = 1'b1;
		samples.pin_levels = levels;
		last_levels = levels;
		@(posedge clk);
		while (!samples.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data = data;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// a tick with no report may still be in the counter sweep, hence the settle time
	task automatic wait_idle();
		int waited;
		samples.valid = 1'b0;
		waited = 0;
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_random_phase(input int count);
		int burst_left;
		bit no_gaps;
		logic [IN_WIDTH-1:0] lv;
		no_gaps = ($urandom_range(0, 3) == 0);
		burst_left = $urandom_range(1, 8);
		lv = last_levels;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(0, 3))
				0: lv = 8'($urandom_range(0, 255));
				1: lv = lv ^ 8'($urandom_range(1, 255));
				2: begin
					// per-channel square waves of different period and duty
					for (int c = 0; c < CHANNELS; c++)
						lv[c] = ((pwm_step % (c + 2)) <= c / 2);
					pwm_step++;
				end
				default: begin
				end
			endcase
			send_tick(lv);
			if (!no_gaps) begin
				burst_left--;
				if (burst_left == 0) begin
					samples.valid = 1'b0;
					repeat ($urandom_range(1, 6)) @(negedge clk);
					burst_left = $urandom_range(1, 8);
				end
			end
		end
		samples.valid = 1'b0;
	endtask

	initial begin
		int random_sent;
		int phase;
		int count;
		sb = new();
		arst_n = 1'b0;
		hold_request = 1'b0;
		pwm_step = 0;
		last_levels = '0;
		samples.valid = 1'b0;
		samples.pin_levels = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// short periods, spare indexes must not disturb the registers
		write_reg(REG_TICKS_PER_REPORT, 16'd3);
		write_reg(REG_TICK_PERIOD_MS, 16'd2);
		write_reg(REG_SPARE_A, 16'h0001);
		write_reg(REG_SPARE_B, 16'h0005);
		send_tick(8'h00);
		send_tick(8'hFF);
		send_tick(8'h55);
		send_tick(8'hAA);
		send_tick(8'h55);
		send_tick(8'hAA);
		wait_idle();

		// one-tick period with a zero tick period
		write_reg(REG_TICKS_PER_REPORT, 16'd1);
		write_reg(REG_TICK_PERIOD_MS, 16'd0);
		send_tick(8'hFF);
		send_tick(8'h00);
		send_tick(8'hF0);
		wait_idle();

		// longest period, then cut short: counts exceed the new length,
		// so duty and frequency clamp; upper data bits of the ms register drop
		write_reg(REG_TICKS_PER_REPORT, 16'hFFFF);
		write_reg(REG_TICK_PERIOD_MS, 16'hFC05);
		for (int i = 0; i < 6; i++)
			send_tick(i[0] ? 8'h00 : 8'hFF);
		wait_idle();
		write_reg(REG_TICKS_PER_REPORT, 16'd2);
		write_reg(REG_TICK_PERIOD_MS, 16'd1);
		send_tick(8'hFF);
		wait_idle();

		// zero length means 65536 ticks: no report until the period is cut short;
		// ch0 stuck high, ch1 stuck low, ch2 toggles every tick
		write_reg(REG_TICKS_PER_REPORT, 16'd0);
		write_reg(REG_TICK_PERIOD_MS, 16'd1000);
		for (int i = 0; i < ZERO_LEN_TICKS; i++)
			send_tick({5'($urandom_range(0, 31)), i[0], 1'b0, 1'b1});
		wait_idle();
		write_reg(REG_TICKS_PER_REPORT, 16'd3);
		send_tick(8'h0F);
		wait_idle();

		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_TICKS) begin
			case ($urandom_range(0, 5))
				0: write_reg(REG_TICKS_PER_REPORT, 16'd1);
				1: write_reg(REG_TICKS_PER_REPORT, 16'd2);
				2, 3, 4: write_reg(REG_TICKS_PER_REPORT, 16'($urandom_range(3, 12)));
				default: write_reg(REG_TICKS_PER_REPORT, 16'($urandom_range(13, 40)));
			endcase
			case ($urandom_range(0, 4))
				0: write_reg(REG_TICK_PERIOD_MS, 16'd0);
				1: write_reg(REG_TICK_PERIOD_MS, 16'd1);
				2: write_reg(REG_TICK_PERIOD_MS, 16'd1000);
				3: write_reg(REG_TICK_PERIOD_MS, 16'hFFFF);
				default: write_reg(REG_TICK_PERIOD_MS, 16'($urandom_range(2, 999)));
			endcase
			count = $urandom_range(10, 40);
			if (phase == 1) begin
				// receiver blocked while ticks keep coming: reports back up into the input
				write_reg(REG_TICKS_PER_REPORT, 16'd2);
				hold_request = 1'b1;
			end
			run_random_phase(count);
			random_sent += count;
			phase++;
			wait_idle();
		end

		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d expected reports never arrived", sb.pending()));
		$display("Run covered %0d sample ticks, %0d channel reports, %0d register writes,",
			sb.ticks_seen, sb.reports_checked, sb.regs_written);
		$display("periods of 1 to 40 ticks, a zero length cut short, clamped ratios, %0d cycles",
			cycle_count);
		if (sb.mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/mcpm_pkg.sv
rtl/mcpm_if.sv
rtl/mcpm_cnt_ram.sv
rtl/mcpm_div.sv
rtl/multi_channel_pwm_meter.sv
tb/sv/tb.sv
